/* src/mdh_pkg.sv */
// Package with widths, constants and the sequencer state type of the modulated delay line.
`timescale 1ns / 1ps

package mdh_pkg;

   localparam int DEPTH        = 2048;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int SAMPLE_W     = 24;
   localparam int OFFSET_W     = 21;
   localparam int COEFF_W      = 16;
   localparam int FRAC_W       = 16;
   localparam int BASE_DELAY   = 64;
   localparam int DELAY_W      = ADDR_W + FRAC_W;
   localparam int DELAY_MIN_Q8 = 4 * 256;
   localparam int DELAY_MAX_Q8 = (DEPTH - 4) * 256;
   localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(131);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULK,
      ST_UPD,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5
   } state_type;

endpackage

/* src/mdh_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mdh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/modulated_delay_hermite.sv */
// Top level of the modulated fractional delay line with 4-point Hermite interpolation.
// An accepted item passes through states ST_MULK, ST_UPD, ST_RD0 to ST_RD3 and ST_M1 to ST_M5
// before rsp_valid rises; ST_M5 waits while a held result is stalled. Items are taken one at a
// time, since the write and four tap reads go in series through the single buffer RAM,
// followed by the three-multiply Horner chain. Reset: synchronous; afterwards a clearing
// pass zeroes the buffer, with req_stall held high, while csr writes are taken as usual.
`timescale 1ns / 1ps

module modulated_delay_hermite
   import mdh_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [COEFF_W-1:0]         csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic signed [OFFSET_W-1:0] req_delay_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   localparam int TOTAL_W = OFFSET_W + 3;
   localparam int Q8_W    = DELAY_W - 8;
   localparam int DIFF_W  = DELAY_W + 1;
   localparam int PROD_W  = COEFF_W + 1 + DIFF_W;
   localparam int K1_W    = SAMPLE_W + 1;
   localparam int K_W     = SAMPLE_W + 4;
   localparam int P1_W    = K_W + FRAC_W + 1;
   localparam int H1_W    = K_W + 1;
   localparam int P2_W    = H1_W + FRAC_W + 1;
   localparam int H2_W    = H1_W + 1;
   localparam int P3_W    = H2_W + FRAC_W + 1;
   localparam int Y_W     = H2_W + 2;

   localparam logic signed [Y_W-1:0] SMIN = -(Y_W'(1) <<< (SAMPLE_W - 1));
   localparam logic signed [Y_W-1:0] SMAX = (Y_W'(1) <<< (SAMPLE_W - 1)) - Y_W'(1);

   state_type state_ff, state_in;

   logic [COEFF_W-1:0]         coeff_ff, coeff_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic [DELAY_W-1:0]         smoothed_ff, smoothed_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [ADDR_W-1:0]          i0_ff, i0_in;
   logic [FRAC_W-1:0]          t_ff, t_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [K1_W-1:0]     k1_ff, k1_in;
   logic signed [K_W-1:0]      k2_ff, k2_in, k3_ff, k3_in;
   logic signed [P1_W-1:0]     p1_ff, p1_in;
   logic signed [P2_W-1:0]     p2_ff, p2_in;
   logic signed [P3_W-1:0]     p3_ff, p3_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       mem_wr_en;
   logic [ADDR_W-1:0]          mem_wr_addr;
   logic [SAMPLE_W-1:0]        mem_wr_data;
   logic [ADDR_W-1:0]          mem_rd_addr;
   logic [SAMPLE_W-1:0]        mem_rd_data;
   logic signed [SAMPLE_W-1:0] tap;

   logic signed [TOTAL_W-1:0]  total_sum;
   logic [Q8_W-1:0]            total_q8;
   logic signed [PROD_W-1:0]   smooth_step;
   logic [DELAY_W-1:0]         pos;
   logic signed [FRAC_W:0]     t_ext;
   logic signed [H1_W-1:0]     h1;
   logic signed [H2_W-1:0]     h2;
   logic signed [P3_W-1:0]     y_step;
   logic signed [Y_W-1:0]      y;

   logic req_accept;
   logic rsp_accept;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign tap        = $signed(mem_rd_data);
   assign t_ext      = $signed({1'b0, t_ff});

   mdh_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MULK;
            end
         end
         ST_MULK: state_in = ST_UPD;
         ST_UPD:  state_in = ST_RD0;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_RD3;
         ST_RD3:  state_in = ST_M1;
         ST_M1:   state_in = ST_M2;
         ST_M2:   state_in = ST_M3;
         ST_M3:   state_in = ST_M4;
         ST_M4:   state_in = ST_M5;
         ST_M5: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wp_ff;
      mem_wr_data = x_ff;
      mem_rd_addr = i0_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: req_stall = 1'b0;
         ST_MULK: mem_wr_en = 1'b1;
         ST_RD0:  mem_rd_addr = pos[DELAY_W-1:FRAC_W] - ADDR_W'(1);
         ST_RD1:  mem_rd_addr = i0_ff;
         ST_RD2:  mem_rd_addr = i0_ff + ADDR_W'(1);
         ST_RD3:  mem_rd_addr = i0_ff + ADDR_W'(2);
         default: ;
      endcase
   end

   always_comb begin
      total_sum = TOTAL_W'(BASE_DELAY * 256)
                + {{(TOTAL_W - OFFSET_W){req_delay_offset[OFFSET_W-1]}}, req_delay_offset};
      if (total_sum < TOTAL_W'(DELAY_MIN_Q8)) begin
         total_q8 = Q8_W'(DELAY_MIN_Q8);
      end else if (total_sum > TOTAL_W'(DELAY_MAX_Q8)) begin
         total_q8 = Q8_W'(DELAY_MAX_Q8);
      end else begin
         total_q8 = total_sum[Q8_W-1:0];
      end
      smooth_step = (prod_ff + PROD_W'(32768)) >>> FRAC_W;
      pos         = {wp_ff, {FRAC_W{1'b0}}} - smoothed_ff;
      h1          = H1_W'(p1_ff >>> FRAC_W) + H1_W'(k2_ff);
      h2          = H2_W'(p2_ff >>> FRAC_W) + H2_W'(k1_ff);
      y_step      = (p3_ff + P3_W'(65536)) >>> (FRAC_W + 1);
      y           = Y_W'(b_ff) + Y_W'(y_step);
   end

   always_comb begin
      coeff_in     = coeff_ff;
      clr_addr_in  = clr_addr_ff;
      wp_in        = wp_ff;
      smoothed_in  = smoothed_ff;
      x_in         = x_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      i0_in        = i0_ff;
      t_in         = t_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      k3_in        = k3_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_data_in  = rsp_data_ff;
      if (csr_wr_en) begin
         coeff_in = csr_wr_data;
      end
      case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (req_accept) begin
               x_in    = req_sample_in;
               diff_in = $signed({1'b0, total_q8, 8'b0}) - $signed({1'b0, smoothed_ff});
            end
         end
         ST_MULK: prod_in = $signed({1'b0, coeff_ff}) * diff_ff;
         ST_UPD:  smoothed_in = smoothed_ff + smooth_step[DELAY_W-1:0];
         ST_RD0: begin
            i0_in = pos[DELAY_W-1:FRAC_W];
            t_in  = pos[FRAC_W-1:0];
         end
         ST_RD1: a_in = tap;
         ST_RD2: b_in = tap;
         ST_RD3: c_in = tap;
         ST_M1: begin
            k1_in = K1_W'(c_ff) - K1_W'(a_ff);
            k2_in = (K_W'(a_ff) <<< 1) - K_W'(b_ff) * K_W'(5) + (K_W'(c_ff) <<< 2)
                  - K_W'(tap);
            k3_in = K_W'(3) * (K_W'(b_ff) - K_W'(c_ff)) + K_W'(tap) - K_W'(a_ff);
            wp_in = wp_ff + ADDR_W'(1);
         end
         ST_M2: p1_in = k3_ff * t_ext;
         ST_M3: p2_in = h1 * t_ext;
         ST_M4: p3_in = h2 * t_ext;
         ST_M5: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (y < SMIN) begin
                  rsp_data_in = SMIN[SAMPLE_W-1:0];
               end else if (y > SMAX) begin
                  rsp_data_in = SMAX[SAMPLE_W-1:0];
               end else begin
                  rsp_data_in = y[SAMPLE_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         coeff_ff     <= COEFF_RESET;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coeff_ff     <= coeff_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         smoothed_ff  <= smoothed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      i0_ff       <= i0_in;
      t_ff        <= t_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      k3_ff       <= k3_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      p3_ff       <= p3_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MULK)
      else $error("An accepted item did not start the sequence.");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_M5)
      else $error("A result appeared outside the final step.");

   a_wp_advances: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_M1 && !$past(reset)) |-> wp_ff == $past(wp_ff) + ADDR_W'(1))
      else $error("The write pointer did not advance by one item.");

   a_smoothed_bounded: assert property (@(posedge clock) disable iff (reset)
      smoothed_ff <= DELAY_W'(DELAY_MAX_Q8 * 256))
      else $error("The smoothed delay left its range.");

   a_write_only_when_owned: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_MULK))
      else $error("The buffer was written outside the clear pass or the sample write.");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the modulated Hermite fractional delay line.
`timescale 1ns / 1ps

module testbench
   import mdh_pkg::*;
();

   typedef enum logic {ROW_ITEM, ROW_COEFF} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] sample;
      logic [OFFSET_W-1:0] offset;
      logic [COEFF_W-1:0]  coeff;
      logic                has_known;
      logic [SAMPLE_W-1:0] known_out;
   } stim_row_type;

   localparam longint RING_Q16 = longint'(DEPTH) << FRAC_W;
   localparam longint OUT_MIN  = -(longint'(1) << (SAMPLE_W - 1));
   localparam longint OUT_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [COEFF_W-1:0]         csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic signed [OFFSET_W-1:0] req_delay_offset;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;

   logic signed [SAMPLE_W-1:0] line_model [0:DEPTH-1];
   logic [ADDR_W-1:0]          wpos_model;
   longint                     smoothed_model;
   logic [COEFF_W-1:0]         coeff_model;

   logic signed [SAMPLE_W-1:0] expected_q [$];
   stim_row_type               directed_rows [$];
   int                         fail_count;
   int                         max_req_gap;
   int                         max_rsp_gap;

   modulated_delay_hermite dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_delay_offset (req_delay_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic signed [SAMPLE_W-1:0] predict_output(
      input logic signed [SAMPLE_W-1:0] smp,
      input logic signed [OFFSET_W-1:0] ofs);
      longint total, pos, a, b, c, d, t, k1, k2, k3, h, y, k;
      logic [ADDR_W-1:0] i0, ia, ic, id;
      total = longint'(BASE_DELAY) * 256 + longint'(ofs);
      if (total < DELAY_MIN_Q8) total = DELAY_MIN_Q8;
      if (total > DELAY_MAX_Q8) total = DELAY_MAX_Q8;
      total = total * 256;
      k = longint'(coeff_model);
      smoothed_model = smoothed_model + ((k * (total - smoothed_model) + 32768) >>> 16);
      line_model[wpos_model] = smp;
      pos = (longint'(wpos_model) << FRAC_W) - smoothed_model;
      pos = pos % RING_Q16;
      if (pos < 0) pos = pos + RING_Q16;
      i0 = ADDR_W'(pos >>> FRAC_W);
      t = pos & 64'hFFFF;
      ia = i0 - ADDR_W'(1);
      ic = i0 + ADDR_W'(1);
      id = i0 + ADDR_W'(2);
      a = line_model[ia];
      b = line_model[i0];
      c = line_model[ic];
      d = line_model[id];
      k1 = c - a;
      k2 = 2 * a - 5 * b + 4 * c - d;
      k3 = 3 * (b - c) + d - a;
      h = ((k3 * t) >>> 16) + k2;
      h = ((h * t) >>> 16) + k1;
      y = b + ((h * t + 65536) >>> 17);
      if (y < OUT_MIN) y = OUT_MIN;
      if (y > OUT_MAX) y = OUT_MAX;
      wpos_model = wpos_model + ADDR_W'(1);
      return SAMPLE_W'(y);
   endfunction

   function automatic void report_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endfunction

   function automatic void add_item(input logic [SAMPLE_W-1:0] smp,
                                    input logic [OFFSET_W-1:0] ofs,
                                    input logic has_known,
                                    input logic [SAMPLE_W-1:0] known);
      directed_rows.push_back({ROW_ITEM, smp, ofs, {COEFF_W{1'b0}}, has_known, known});
   endfunction

   function automatic void add_coeff(input logic [COEFF_W-1:0] v);
      directed_rows.push_back({ROW_COEFF, {SAMPLE_W{1'b0}}, {OFFSET_W{1'b0}}, v, 1'b0,
                               {SAMPLE_W{1'b0}}});
   endfunction

   task automatic send_item(input logic signed [SAMPLE_W-1:0] smp,
                            input logic signed [OFFSET_W-1:0] ofs,
                            input logic has_known,
                            input logic signed [SAMPLE_W-1:0] known);
      int gap;
      logic signed [SAMPLE_W-1:0] predicted;
      gap = $urandom_range(max_req_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_in    <= smp;
      req_delay_offset <= ofs;
      do @(posedge clock); while (req_stall);
      predicted = predict_output(smp, ofs);
      expected_q.push_back(has_known ? known : predicted);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_coeff(input logic [COEFF_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      coeff_model = v;
   endtask

   initial begin : response_side
      int stall_len;
      logic signed [SAMPLE_W-1:0] want;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall_len = $urandom_range(max_rsp_gap, 0);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_q.size() == 0) begin
            report_failure($sformatf("unexpected item: sample_out %0d", rsp_sample_out));
         end else begin
            want = expected_q.pop_front();
            if (rsp_sample_out !== want)
               report_failure($sformatf("sample_out mismatch: expected %0d, actual %0d",
                                        want, rsp_sample_out));
         end
      end
   end

   initial begin : stimulus_side
      int sweep;
      int phase;
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [OFFSET_W-1:0] ofs;
      logic [COEFF_W-1:0] cv;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      req_delay_offset = '0;
      fail_count       = 0;
      max_req_gap      = 12;
      max_rsp_gap      = 12;
      foreach (line_model[i]) line_model[i] = '0;
      wpos_model     = '0;
      smoothed_model = 0;
      coeff_model    = COEFF_RESET;

      // With no smoothing the delay stays at zero, so each item returns its own sample.
      add_coeff(16'd0);
      add_item(24'h000000, 21'h000000, 1'b1, 24'h000000);
      add_item(24'h7FFFFF, 21'h0FFFFF, 1'b1, 24'h7FFFFF);
      add_item(24'h800000, 21'h100000, 1'b1, 24'h800000);
      add_item(24'h000001, 21'h100000, 1'b1, 24'h000001);
      add_item(24'hFFFFFF, 21'h0FFFFF, 1'b1, 24'hFFFFFF);
      add_item(24'h555555, 21'h0AAAAA, 1'b1, 24'h555555);
      add_item(24'hAAAAAA, 21'h155555, 1'b1, 24'hAAAAAA);
      add_coeff(16'hFFFF);
      add_item(24'h7FFFFF, 21'h0FFFFF, 1'b0, '0);
      add_item(24'h800000, 21'h100000, 1'b0, '0);
      add_item(24'h123456, 21'h000000, 1'b0, '0);
      // Square pattern at four and a half samples of delay drives the interpolation past full scale.
      for (int i = 0; i < 8; i++)
         add_item((i % 4 < 2) ? 24'h7FFFFF : 24'h800000, OFFSET_W'(-15232), 1'b0, '0);
      add_item(24'h3C0FFE, 21'h000025, 1'b0, '0);
      add_coeff(COEFF_RESET);
      add_item(24'h0ABCDE, 21'h000080, 1'b0, '0);
      add_item(24'hF54321, 21'h000000, 1'b0, '0);
      add_coeff(16'd1);
      add_item(24'h400000, 21'h001000, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_COEFF) begin
            drain_results();
            write_coeff(directed_rows[i].coeff);
         end else begin
            send_item(directed_rows[i].sample, directed_rows[i].offset,
                      directed_rows[i].has_known, directed_rows[i].known_out);
         end
      end

      sweep = 0;
      for (phase = 0; phase < 8; phase++) begin
         drain_results();
         case (phase)
            0: cv = 16'hFFFF;
            1: cv = 16'd0;
            2: cv = 16'd1;
            3: cv = COEFF_W'($urandom_range(65535));
            4: cv = COEFF_W'($urandom_range(2000));
            5: cv = COEFF_RESET;
            6: cv = COEFF_W'($urandom_range(65535));
            default: cv = 16'h8000;
         endcase
         write_coeff(cv);
         max_req_gap = ($urandom_range(3) == 0) ? 0 : 12;
         max_rsp_gap = ($urandom_range(3) == 0) ? 0 : 12;
         for (int n = 0; n < 212; n++) begin
            case ($urandom_range(9))
               0: smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
               1: smp = SAMPLE_W'($urandom_range(2047)) - SAMPLE_W'(1024);
               default: smp = SAMPLE_W'($urandom);
            endcase
            case ($urandom_range(9))
               0: ofs = OFFSET_W'($urandom);
               1: begin
                  sweep = $urandom_range(526000) - 16384;
                  ofs = OFFSET_W'(sweep);
               end
               default: begin
                  sweep = sweep + $urandom_range(512) - 256;
                  if (sweep < -16384) sweep = -16384;
                  if (sweep > 510000) sweep = 510000;
                  ofs = OFFSET_W'(sweep);
               end
            endcase
            send_item(smp, ofs, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && expected_q.size() != 0; n++) @(posedge clock);
      repeat (24) @(posedge clock);
      if (expected_q.size() != 0)
         report_failure($sformatf("%0d expected items never arrived", expected_q.size()));
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
